// ===== src/srf_pkg.sv =====
package srf_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 28;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] IDX_ADDR_HI  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_ADDR_MID = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_ADDR_LO  = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_VERSION  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_UNIT_LO  = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_UNIT_HI  = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_FLAGS    = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_TEMP     = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_SUM      = IDX_W'(FRAME_LEN - 1);

  // Flags byte layout
  localparam int FLAG_BAD_BIT  = 7;
  localparam int FLAG_LOST_BIT = 6;
  localparam int COUNT_W       = 4;

  // Register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATEWAY = 2'd0,
    REG_VERSION = 2'd1,
    REG_UNIT    = 2'd2
  } reg_idx_t;

  localparam logic [23:0] GATEWAY_RESET = 24'h142402;
  localparam logic [7:0]  VERSION_RESET = 8'h01;
  localparam logic [15:0] UNIT_RESET    = 16'h0003;

  // One classified message waiting to be serialized
  typedef struct packed {
    logic [7:0]  flags;
    logic [31:0] co2;
    logic [31:0] humid;
    logic [31:0] temp;
  } entry_t;

  // Configuration seen by the serializer
  typedef struct packed {
    logic [23:0] gateway_addr;
    logic [7:0]  proto_version;
    logic [15:0] unit_id;
  } cfg_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Serializer status
  typedef struct packed {
    logic             pop;
    logic [IDX_W-1:0] idx;
  } bstat_t;

endpackage

// ===== src/srf_front.sv =====
module srf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [31:0]            seq_count,
  input  logic [31:0]            temp_bits,
  input  logic [31:0]            humid_bits,
  input  logic [31:0]            co2_level,
  input  logic [31:0]            rx_sum,
  output srf_pkg::entry_t        entry
);

  logic [31:0]                  last_seq;
  logic [srf_pkg::COUNT_W-1:0]  frame_count;
  logic                         started;
  logic [11:0]                  calc;
  logic                         good;
  logic                         lost;

  function automatic logic [9:0] byte_sum32(input logic [31:0] w);
    byte_sum32 = (10'(w[7:0]) + 10'(w[15:8])) + (10'(w[23:16]) + 10'(w[31:24]));
  endfunction

  // Check the byte sum and the sequence number
  always_comb begin
    calc = (12'(byte_sum32(seq_count)) + 12'(byte_sum32(temp_bits)))
         + (12'(byte_sum32(humid_bits)) + 12'(byte_sum32(co2_level)));
    good = ({20'd0, calc} == rx_sum);
    lost = started && (seq_count != last_seq + 32'd1);
  end

  // Build the queue entry; readings are blanked on a bad checksum
  always_comb begin
    entry.flags = {~good, lost, 2'b00, frame_count};
    entry.temp  = good ? temp_bits  : 32'd0;
    entry.humid = good ? humid_bits : 32'd0;
    entry.co2   = good ? co2_level  : 32'd0;
  end

  // Advance sequence tracking and frame counter per accepted message
  always_ff @(posedge clk) begin
    if (rst) begin
      last_seq    <= 32'd0;
      frame_count <= '0;
      started     <= 1'b0;
    end else if (accept) begin
      last_seq    <= seq_count;
      frame_count <= frame_count + 1'b1;
      started     <= 1'b1;
    end
  end

endmodule

// ===== src/srf_queue.sv =====
module srf_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srf_pkg::entry_t wr_entry,
  input  logic            pop,
  output srf_pkg::entry_t rd_entry,
  output srf_pkg::qstat_t stat
);

  // DEPTH is a power of two, at least 2
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  srf_pkg::entry_t   slots [DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign rd_entry   = slots[rptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/srf_back.sv =====
module srf_back (
  input  logic            clk,
  input  logic            rst,
  input  srf_pkg::cfg_t   cfg,
  input  srf_pkg::entry_t entry,
  input  logic            avail,
  output srf_pkg::bstat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic [srf_pkg::IDX_W-1:0] idx;
  logic [srf_pkg::IDX_W-1:0] off;
  logic [7:0]                sum;
  logic [7:0]                cur;
  logic [255:0]              payload;
  logic                      emit;
  logic                      at_end;
  logic                      summed;

  assign emit   = avail && (!out_valid || out_ready);
  assign at_end = (idx == srf_pkg::IDX_SUM);
  assign summed = (idx >= srf_pkg::IDX_VERSION) && (idx < srf_pkg::IDX_SUM);

  assign stat.pop = emit && at_end;
  assign stat.idx = idx;

  // Pick the current frame byte
  always_comb begin
    payload = {160'd0, entry.co2, entry.humid, entry.temp};
    off     = idx - srf_pkg::IDX_TEMP;
    case (idx)
      srf_pkg::IDX_ADDR_HI:  cur = cfg.gateway_addr[23:16];
      srf_pkg::IDX_ADDR_MID: cur = cfg.gateway_addr[15:8];
      srf_pkg::IDX_ADDR_LO:  cur = cfg.gateway_addr[7:0];
      srf_pkg::IDX_VERSION:  cur = cfg.proto_version;
      srf_pkg::IDX_UNIT_LO:  cur = cfg.unit_id[7:0];
      srf_pkg::IDX_UNIT_HI:  cur = cfg.unit_id[15:8];
      srf_pkg::IDX_FLAGS:    cur = entry.flags;
      srf_pkg::IDX_SUM:      cur = sum;
      default:               cur = payload[{off, 3'b000} +: 8];
    endcase
  end

  // Advance byte index and running sum per emitted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= at_end ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (idx == srf_pkg::IDX_ADDR_HI) begin
        sum <= 8'd0;
      end else if (summed) begin
        sum <= sum + cur;
      end
    end
  end

  // Output register: load on emit, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= cur;
      out_last <= at_end;
    end
  end

endmodule

// ===== src/sensor_frame_relay_unit.sv =====
// Sensor frame relay. Each transfer on the s_ side is one received sensor
// message; the block checks its 32-bit byte-sum checksum, flags a gap in the
// sequence number (never on the first message after reset) and sends a
// 28-byte uplink frame on the m_ side, one byte per transfer, with m_tlast on
// the closing checksum byte. A message is checked and queued in the cycle it
// is transferred; the serializer then loads its frame byte by byte from the
// queue head into the single byte-wide output register, holding while
// m_tready is low, so a frame's first byte leaves only after its message is
// queued. The queue holds QUEUE_DEPTH messages (a power of two, at least 2),
// the one being serialized included, so QUEUE_DEPTH - 1 messages can wait
// behind the frame in flight and s_tready stays high until that queue fills.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 gateway
// address, 1 protocol version, 2 unit id; other indexes are ignored. The user
// must write them only while the block is idle; the block does not enforce it.
module sensor_frame_relay_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // seq_count, temp_bits, humid_bits, co2_level, rx_sum (32 bits each)
  input  logic [159:0]                   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // frame_byte
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [srf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srf_pkg::CFG_DATA_W-1:0] cfg_data
);

  srf_pkg::cfg_t   cfg;
  srf_pkg::entry_t front_entry;
  srf_pkg::entry_t head_entry;
  srf_pkg::qstat_t qstat;
  srf_pkg::bstat_t bstat;
  logic            accept;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gateway_addr  <= srf_pkg::GATEWAY_RESET;
      cfg.proto_version <= srf_pkg::VERSION_RESET;
      cfg.unit_id       <= srf_pkg::UNIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        srf_pkg::REG_GATEWAY: cfg.gateway_addr  <= cfg_data[23:0];
        srf_pkg::REG_VERSION: cfg.proto_version <= cfg_data[7:0];
        srf_pkg::REG_UNIT:    cfg.unit_id       <= cfg_data[15:0];
        default:              cfg.unit_id       <= cfg.unit_id;
      endcase
    end
  end

  srf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .seq_count  (s_tdata[31:0]),
    .temp_bits  (s_tdata[63:32]),
    .humid_bits (s_tdata[95:64]),
    .co2_level  (s_tdata[127:96]),
    .rx_sum     (s_tdata[159:128]),
    .entry      (front_entry)
  );

  srf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .wr_entry (front_entry),
    .pop      (bstat.pop),
    .rd_entry (head_entry),
    .stat     (qstat)
  );

  srf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .entry     (head_entry),
    .avail     (!qstat.empty),
    .stat      (bstat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

  // The queue never takes a message while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(accept && qstat.full))
    else $error("message pushed into a full queue");

  // A message leaves the queue only when its last byte is produced
  a_pop_at_end: assert property (@(posedge clk) disable iff (rst)
    bstat.pop |-> (bstat.idx == srf_pkg::IDX_SUM) && !qstat.empty)
    else $error("queue popped before the frame was complete");

  // After the closing byte is produced the next frame starts at byte zero
  a_restart: assert property (@(posedge clk) disable iff (rst)
    bstat.pop |=> (bstat.idx == srf_pkg::IDX_ADDR_HI) && m_tlast)
    else $error("frame index did not restart after the checksum byte");

endmodule

// ===== bench/sensor_frame_relay_unit_tb.sv =====
module sensor_frame_relay_unit_tb;

  localparam int LIMIT_CYCLES     = 500000;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_FRAME  = 60;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int MAX_REPORTS      = 40;
  localparam int WORDS_PER_FRAME  = 5;

  // Index beyond the register map; writes to it must be dropped
  localparam logic [srf_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // One received sensor message, seq_count in the lowest bits
  typedef struct packed {
    logic [31:0] rx_sum;
    logic [31:0] co2;
    logic [31:0] humid;
    logic [31:0] temp;
    logic [31:0] seq;
  } sensor_msg_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  // seq_count, temp_bits, humid_bits, co2_level, rx_sum (32 bits each)
  logic [159:0]                   s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  // frame_byte
  logic [7:0]                     m_tdata;
  logic                           m_tlast;
  logic                           cfg_we = 1'b0;
  logic [srf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [srf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  sensor_frame_relay_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state and register copies
  logic [23:0]                 cfg_gateway;
  logic [7:0]                  cfg_version;
  logic [15:0]                 cfg_unit;
  logic [31:0]                 prev_seq;
  logic [srf_pkg::COUNT_W-1:0] frame_cnt;
  logic                        seq_seen;

  sensor_msg_t msg_q[$];
  frame_byte_t frame_q[$];
  frame_byte_t want;
  int          errors = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  logic [31:0] gen_seq;

  logic [15:0] ready_mask = '1;
  logic [3:0]  mask_pos = '0;
  int          hold_left = 0;
  int          frames_out = 0;
  logic        held_once = 1'b0;
  int unsigned cycle_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] byte_total(input logic [31:0] w);
    return 32'(w[7:0]) + 32'(w[15:8]) + 32'(w[23:16]) + 32'(w[31:24]);
  endfunction

  // Build a message whose checksum matches its data bytes
  function automatic sensor_msg_t make_msg(input logic [31:0] seq, input logic [31:0] temp,
                                           input logic [31:0] humid, input logic [31:0] co2);
    sensor_msg_t m;
    m.seq    = seq;
    m.temp   = temp;
    m.humid  = humid;
    m.co2    = co2;
    m.rx_sum = byte_total(seq) + byte_total(temp) + byte_total(humid) + byte_total(co2);
    return m;
  endfunction

  // Work out the uplink frame for one message and queue its bytes
  function automatic void predict_frame(input sensor_msg_t m);
    logic [7:0]  fr [srf_pkg::FRAME_LEN];
    logic [31:0] vals [WORDS_PER_FRAME];
    logic [7:0]  flags;
    logic [7:0]  sum;
    logic        good;
    frame_byte_t fb;
    good  = (byte_total(m.seq) + byte_total(m.temp) + byte_total(m.humid)
             + byte_total(m.co2)) == m.rx_sum;
    flags = 8'(frame_cnt);
    if (!good)
      flags[srf_pkg::FLAG_BAD_BIT] = 1'b1;
    if (seq_seen && m.seq != prev_seq + 32'd1)
      flags[srf_pkg::FLAG_LOST_BIT] = 1'b1;
    prev_seq  = m.seq;
    seq_seen  = 1'b1;
    frame_cnt = frame_cnt + 1'b1;

    fr[srf_pkg::IDX_ADDR_HI]  = cfg_gateway[23:16];
    fr[srf_pkg::IDX_ADDR_MID] = cfg_gateway[15:8];
    fr[srf_pkg::IDX_ADDR_LO]  = cfg_gateway[7:0];
    fr[srf_pkg::IDX_VERSION]  = cfg_version;
    fr[srf_pkg::IDX_UNIT_LO]  = cfg_unit[7:0];
    fr[srf_pkg::IDX_UNIT_HI]  = cfg_unit[15:8];
    fr[srf_pkg::IDX_FLAGS]    = flags;
    vals[0] = good ? m.temp : '0;
    vals[1] = good ? m.humid : '0;
    vals[2] = good ? m.co2 : '0;
    vals[3] = '0;
    vals[4] = '0;
    for (int w = 0; w < WORDS_PER_FRAME; w++)
      for (int k = 0; k < 4; k++)
        fr[srf_pkg::IDX_TEMP + 4 * w + k] = vals[w][8 * k +: 8];

    // Checksum covers everything after the address bytes
    sum = '0;
    for (int i = srf_pkg::IDX_VERSION; i < srf_pkg::IDX_SUM; i++)
      sum += fr[i];
    fr[srf_pkg::IDX_SUM] = sum;

    for (int i = 0; i < srf_pkg::FRAME_LEN; i++) begin
      fb.value = fr[i];
      fb.last  = (i == srf_pkg::IDX_SUM);
      frame_q.push_back(fb);
    end
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-order messages with good sums; some gaps, backward steps and bad sums
  task automatic queue_random(input int count);
    sensor_msg_t m;
    repeat (count) begin
      case ($urandom_range(0, 19))
        0, 1: gen_seq = $urandom;
        2: gen_seq = gen_seq - 32'd1;
        3: gen_seq = 32'hFFFF_FFFF - $urandom_range(0, 2);
        default: gen_seq = gen_seq + 32'd1;
      endcase
      m = make_msg(gen_seq, pick_word(), pick_word(), pick_word());
      case ($urandom_range(0, 9))
        0: m.rx_sum = $urandom;
        1: m.rx_sum = m.rx_sum ^ (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
      msg_q.push_back(m);
    end
  endtask

  // Register write, mirrored into the predictor
  task automatic write_reg(input logic [srf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [srf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srf_pkg::REG_GATEWAY: cfg_gateway = val;
      srf_pkg::REG_VERSION: cfg_version = val[7:0];
      srf_pkg::REG_UNIT:    cfg_unit    = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold until every queued message is sent and every frame byte has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (msg_q.size() != 0 || s_tvalid || frame_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of transfers with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready)
        predict_frame(s_tdata);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (msg_q.size() != 0) begin
          s_tdata  <= msg_q.pop_front();
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a rotating mask, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_mask <= '1;
      mask_pos   <= '0;
      hold_left  <= 0;
      frames_out <= 0;
      held_once  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && m_tlast)
        frames_out <= frames_out + 1;
      if (!held_once && frames_out == LONG_HOLD_FRAME) begin
        held_once <= 1'b1;
        hold_left <= LONG_HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ready_mask[mask_pos];
      end
      mask_pos <= mask_pos + 1'b1;
      if (mask_pos == 4'hF) begin
        case ($urandom_range(0, 3))
          0: ready_mask <= '1;
          1: ready_mask <= 16'($urandom);
          2: ready_mask <= 16'($urandom | $urandom);
          default: ready_mask <= 16'($urandom & $urandom);
        endcase
      end
    end
  end

  // Compare each output transfer with the oldest predicted byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (frame_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected byte: expected none, actual data %02h last %b",
                   $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = frame_q.pop_front();
        if (m_tdata !== want.value) begin
          if (errors < MAX_REPORTS)
            $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                     $time, want.value, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          if (errors < MAX_REPORTS)
            $display("%0t: frame_last mismatch: expected %b, actual %b",
                     $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sensor_msg_t m;
    cfg_gateway = srf_pkg::GATEWAY_RESET;
    cfg_version = srf_pkg::VERSION_RESET;
    cfg_unit    = srf_pkg::UNIT_RESET;
    prev_seq    = '0;
    frame_cnt   = '0;
    seq_seen    = 1'b0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Write to an unmapped index; the reset settings must stay in effect
    write_reg(REG_NONE, '1);

    // First message after reset is never flagged lost, whatever its number
    msg_q.push_back(make_msg(32'd5, '0, '0, '0));
    msg_q.push_back(make_msg(32'd6, '1, '1, '1));
    m = make_msg(32'd7, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9);
    m.rx_sum = m.rx_sum + 32'd1;
    msg_q.push_back(m);
    // Repeated number, then a jump to the top of the range
    msg_q.push_back(make_msg(32'd7, 32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FF00));
    msg_q.push_back(make_msg('1, '1, '1, '1));
    // Wrap from all ones to zero is in order
    msg_q.push_back(make_msg(32'd0, 32'h8000_0001, 32'h7FFF_FFFE, 32'h0000_0001));
    // Gap together with a bad checksum
    m = make_msg(32'd2, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333);
    m.rx_sum = '1;
    msg_q.push_back(m);
    m = make_msg(32'd3, 32'h8000_0000, 32'h0000_0080, 32'h0080_0000);
    m.rx_sum = '0;
    msg_q.push_back(m);
    // Enough in-order frames to wrap the frame counter
    for (int i = 4; i < 16; i++)
      msg_q.push_back(make_msg(i, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA,
                               (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555, $urandom));
    gen_seq = 32'd15;
    wait_idle();

    // Lowest register values
    write_reg(srf_pkg::REG_GATEWAY, '0);
    write_reg(srf_pkg::REG_VERSION, '0);
    write_reg(srf_pkg::REG_UNIT, '0);
    queue_random(100);
    wait_idle();

    // Highest register values
    write_reg(srf_pkg::REG_GATEWAY, '1);
    write_reg(srf_pkg::REG_VERSION, 24'h0000FF);
    write_reg(srf_pkg::REG_UNIT, 24'h00FFFF);
    queue_random(100);
    wait_idle();

    // Random register values
    write_reg(srf_pkg::REG_GATEWAY, 24'($urandom));
    write_reg(srf_pkg::REG_VERSION, 24'($urandom_range(0, 255)));
    write_reg(srf_pkg::REG_UNIT, 24'($urandom_range(0, 65535)));
    queue_random(100);
    wait_idle();

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
src/srf_pkg.sv
src/srf_front.sv
src/srf_queue.sv
src/srf_back.sv
src/sensor_frame_relay_unit.sv
bench/sensor_frame_relay_unit_tb.sv
